// ===== rtl/core/wdc_pkg.sv =====
// Package for the window distinct counter: sizes, word structs and memory
// request structs shared by the core modules. No dependencies.
`default_nettype none

package wdc_pkg;

  // Number of positions and number of distinct values (power of two).
  localparam int POSITIONS = 4096;
  localparam int VALUES    = 65536;

  localparam int POS_W   = 13;                  // position / range field width
  localparam int VAL_W   = 16;                  // value field width
  localparam int CNT_W   = 13;                  // distinct count field width
  localparam int PADDR_W = $clog2(POSITIONS);   // value store address
  localparam int VADDR_W = $clog2(VALUES);      // count store address, stored value
  localparam int OCC_W   = $clog2(POSITIONS + 1);
  localparam int CLR_N   = (POSITIONS > VALUES) ? POSITIONS : VALUES;
  localparam int CLR_W   = $clog2(CLR_N);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] range_left;
    logic [POS_W-1:0] range_right;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] distinct_count;
    logic             range_error;
  } out_word_t;

  typedef struct packed {
    logic               we;
    logic [PADDR_W-1:0] waddr;
    logic [VADDR_W-1:0] wdata;
    logic [PADDR_W-1:0] raddr;
  } vs_req_t;

  typedef struct packed {
    logic               we;
    logic [VADDR_W-1:0] waddr;
    logic [OCC_W-1:0]   wdata;
    logic [VADDR_W-1:0] raddr;
  } cnt_req_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/wdc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered, read-first output. No dependencies.
`default_nettype none

module wdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/wdc_seq.sv =====
// Sequencer for the window distinct counter: window bounds, distinct total,
// and the read-modify-write traffic to the value and count stores.
// Depends on wdc_pkg.
`default_nettype none

module wdc_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire wdc_pkg::in_word_t           word,
  input  wire logic                        out_hold,
  input  wire logic [wdc_pkg::VADDR_W-1:0] vs_rdata,
  input  wire logic [wdc_pkg::OCC_W-1:0]   cnt_rdata,
  output logic                             idle,
  output wdc_pkg::vs_req_t                 vs_req,
  output wdc_pkg::cnt_req_t                cnt_req,
  output wdc_pkg::res_t                    res
);
  import wdc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_STEP   = 8'b0000_0010,
    S_CREAD  = 8'b0000_0100,
    S_CWRITE = 8'b0000_1000,
    S_WOLD   = 8'b0001_0000,
    S_WREM   = 8'b0010_0000,
    S_WADD   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   wl_r, wl_nxt, wr_r, wr_nxt;
  logic [POS_W-1:0]   ql_r, ql_nxt, qr_r, qr_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [VADDR_W-1:0] val_r, val_nxt, old_r, old_nxt;
  logic               kind_r, kind_nxt;   // 1: add an occurrence
  logic               err_r, err_nxt;

  // next window step
  logic               step_any, step_add;
  logic [POS_W-1:0]   step_pos, step_wl, step_wr;
  logic [PADDR_W-1:0] step_addr;

  // occurrence count update
  logic               upd_add, upd_we;
  logic [OCC_W-1:0]   upd_cnt;
  logic [CNT_W-1:0]   upd_total;

  logic               pos_ok, in_win, q_bad;
  logic [PADDR_W-1:0] wr_addr;
  logic [VADDR_W-1:0] new_val;

  assign pos_ok  = (word.position != '0) && (32'(word.position) <= POSITIONS);
  assign in_win  = (word.position >= wl_r) && (word.position <= wr_r);
  assign q_bad   = (word.range_left == '0) || (32'(word.range_right) > POSITIONS) ||
                   (word.range_left > word.range_right);
  assign wr_addr = PADDR_W'(word.position - 1'b1);
  assign new_val = VADDR_W'(word.value);
  assign idle    = (state_r == S_IDLE);

  // grow right, grow left, shrink left, shrink right
  always_comb begin
    step_any = 1'b1;
    step_add = 1'b1;
    step_pos = wr_r;
    step_wl  = wl_r;
    step_wr  = wr_r;
    priority if (wr_r < qr_r) begin
      step_pos = wr_r + 1'b1;
      step_wr  = wr_r + 1'b1;
    end else if (wl_r > ql_r) begin
      step_pos = wl_r - 1'b1;
      step_wl  = wl_r - 1'b1;
    end else if (wl_r < ql_r) begin
      step_add = 1'b0;
      step_pos = wl_r;
      step_wl  = wl_r + 1'b1;
    end else if (wr_r > qr_r) begin
      step_add = 1'b0;
      step_pos = wr_r;
      step_wr  = wr_r - 1'b1;
    end else begin
      step_any = 1'b0;
    end
  end

  assign step_addr = PADDR_W'(step_pos - 1'b1);

  always_comb begin
    upd_add   = (state_r == S_WADD) || ((state_r == S_CWRITE) && kind_r);
    upd_cnt   = cnt_rdata;
    upd_total = total_r;
    upd_we    = 1'b0;
    if (upd_add) begin
      upd_we  = 1'b1;
      upd_cnt = cnt_rdata + 1'b1;
      if (cnt_rdata == '0) begin
        upd_total = total_r + 1'b1;
      end
    end else if (cnt_rdata != '0) begin
      upd_we  = 1'b1;
      upd_cnt = cnt_rdata - 1'b1;
      if (cnt_rdata == OCC_W'(1)) begin
        upd_total = total_r - 1'b1;
      end
    end
  end

  // memory requests
  always_comb begin
    vs_req  = '0;
    cnt_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (word.cmd == CMD_WRITE) && pos_ok) begin
          vs_req.raddr = wr_addr;   // read-first: old value comes back
          vs_req.we    = 1'b1;
          vs_req.waddr = wr_addr;
          vs_req.wdata = new_val;
        end
      end
      S_STEP: vs_req.raddr = step_addr;
      S_CREAD: cnt_req.raddr = vs_rdata;
      S_CWRITE: begin
        cnt_req.we    = upd_we;
        cnt_req.waddr = val_r;
        cnt_req.wdata = upd_cnt;
        vs_req.raddr  = step_addr;
      end
      S_WOLD: cnt_req.raddr = vs_rdata;
      S_WREM: begin
        cnt_req.we    = upd_we;
        cnt_req.waddr = old_r;
        cnt_req.wdata = upd_cnt;
        cnt_req.raddr = val_r;
      end
      S_WADD: begin
        cnt_req.we    = upd_we;
        cnt_req.waddr = val_r;
        cnt_req.wdata = upd_cnt;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    wl_nxt    = wl_r;
    wr_nxt    = wr_r;
    ql_nxt    = ql_r;
    qr_nxt    = qr_r;
    total_nxt = total_r;
    val_nxt   = val_r;
    old_nxt   = old_r;
    kind_nxt  = kind_r;
    err_nxt   = err_r;
    res.valid = 1'b0;
    res.word.range_error    = err_r;
    res.word.distinct_count = err_r ? '0 : total_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (word.cmd == CMD_QUERY) begin
            ql_nxt  = word.range_left;
            qr_nxt  = word.range_right;
            err_nxt = q_bad;
            state_nxt = q_bad ? S_DONE : S_STEP;
          end else if (pos_ok && in_win) begin
            val_nxt   = new_val;
            state_nxt = S_WOLD;
          end
        end
      end
      S_STEP, S_CWRITE: begin
        if (state_r == S_CWRITE) begin
          total_nxt = upd_total;
        end
        if (step_any) begin
          wl_nxt    = step_wl;
          wr_nxt    = step_wr;
          kind_nxt  = step_add;
          state_nxt = S_CREAD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CREAD: begin
        val_nxt   = vs_rdata;
        state_nxt = S_CWRITE;
      end
      S_WOLD: begin
        old_nxt   = vs_rdata;
        state_nxt = (vs_rdata == val_r) ? S_IDLE : S_WREM;
      end
      S_WREM: begin
        total_nxt = upd_total;
        state_nxt = S_WADD;
      end
      S_WADD: begin
        total_nxt = upd_total;
        state_nxt = S_IDLE;
      end
      S_DONE: begin
        if (!out_hold) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wl_r    <= POS_W'(1);
      wr_r    <= '0;
      total_r <= '0;
      ql_r    <= POS_W'(1);
      qr_r    <= '0;
    end else begin
      state_r <= state_nxt;
      wl_r    <= wl_nxt;
      wr_r    <= wr_nxt;
      total_r <= total_nxt;
      ql_r    <= ql_nxt;
      qr_r    <= qr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    old_r  <= old_nxt;
    kind_r <= kind_nxt;
    err_r  <= err_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/window_distinct_count_with_updates.sv =====
// Window distinct counter top level: value store, count store, clearing sweep
// and output register. Depends on wdc_pkg, wdc_ram, wdc_seq.
// Words: a write outside the window leaves input free; a write inside it (with
// no count update if the value is unchanged) or a query stalls input until the
// sequencer is idle again. A held query result stalls input too.
// Reset: both stores swept to zero, input stalled meanwhile.
`default_nettype none

module window_distinct_count_with_updates (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wdc_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wdc_pkg::out_word_t       out_word
);
  import wdc_pkg::*;

  logic               clearing_r, clearing_nxt;
  logic [CLR_W-1:0]   clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               seq_idle, accept, out_hold;
  vs_req_t            vs_req, vs_port;
  cnt_req_t           cnt_req, cnt_port;
  res_t               res;
  logic [VADDR_W-1:0] vs_rdata;
  logic [OCC_W-1:0]   cnt_rdata;

  assign in_stall  = clearing_r || !seq_idle;
  assign accept    = in_valid && !in_stall;
  assign out_hold  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  wdc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .word      (in_word),
    .out_hold  (out_hold),
    .vs_rdata  (vs_rdata),
    .cnt_rdata (cnt_rdata),
    .idle      (seq_idle),
    .vs_req    (vs_req),
    .cnt_req   (cnt_req),
    .res       (res)
  );

  // clearing sweep takes over the write ports
  always_comb begin
    vs_port  = vs_req;
    cnt_port = cnt_req;
    if (clearing_r) begin
      vs_port.we     = (32'(clr_r) < POSITIONS);
      vs_port.waddr  = clr_r[PADDR_W-1:0];
      vs_port.wdata  = '0;
      cnt_port.we    = (32'(clr_r) < VALUES);
      cnt_port.waddr = clr_r[VADDR_W-1:0];
      cnt_port.wdata = '0;
    end
  end

  wdc_ram #(.WIDTH(VADDR_W), .DEPTH(POSITIONS)) u_value_ram (
    .clk   (clk),
    .we    (vs_port.we),
    .waddr (vs_port.waddr),
    .wdata (vs_port.wdata),
    .raddr (vs_port.raddr),
    .rdata (vs_rdata)
  );

  wdc_ram #(.WIDTH(OCC_W), .DEPTH(VALUES)) u_count_ram (
    .clk   (clk),
    .we    (cnt_port.we),
    .waddr (cnt_port.waddr),
    .wdata (cnt_port.wdata),
    .raddr (cnt_port.raddr),
    .rdata (cnt_rdata)
  );

  always_comb begin
    clearing_nxt = clearing_r;
    clr_nxt      = clr_r;
    if (clearing_r) begin
      clr_nxt = clr_r + 1'b1;
      if (32'(clr_r) == CLR_N - 1) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res.word;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for window_distinct_count_with_updates: directed and random
// write/query words checked against an in-bench distinct-count predictor.
// Depends on wdc_pkg and the window_distinct_count_with_updates RTL.
`default_nettype none

module tb_top;
  import wdc_pkg::*;

  // The quiet limit must cover the reset sweep plus a full-span query.
  localparam int QUIET_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 500;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  window_distinct_count_with_updates dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: stored values, per-value hit counts, current window.
  bit [VAL_W-1:0] pos_value [1:POSITIONS];
  int unsigned    value_hits [VALUES];
  int unsigned    distinct_now = 0;
  int unsigned    win_lo = 1;
  int unsigned    win_hi = 0;

  out_word_t   expected_counts [$];
  out_word_t   want;
  int unsigned errors = 0;
  int unsigned n_writes = 0;
  int unsigned n_queries = 0;
  int unsigned n_bad_ranges = 0;
  int unsigned n_checked = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned value_at(int unsigned p);
    return (p >= 1 && p <= POSITIONS) ? pos_value[p] : 0;
  endfunction

  function automatic void add_hit(int unsigned v);
    if (value_hits[v] == 0) distinct_now++;
    value_hits[v]++;
  endfunction

  function automatic void drop_hit(int unsigned v);
    if (value_hits[v] != 0) begin
      value_hits[v]--;
      if (value_hits[v] == 0) distinct_now--;
    end
  endfunction

  // Applies one accepted word; returns 1 with the expected result for queries.
  function automatic bit apply_word(input in_word_t w, output out_word_t r);
    int unsigned ql;
    int unsigned qr;
    int unsigned p;
    int unsigned v;
    r = '0;
    if (w.cmd == CMD_WRITE) begin
      p = w.position;
      v = w.value % VALUES;
      if (p >= 1 && p <= POSITIONS) begin
        if (p >= win_lo && p <= win_hi) begin
          drop_hit(value_at(p));
          add_hit(v);
        end
        pos_value[p] = VAL_W'(v);
      end
      return 1'b0;
    end
    ql = w.range_left;
    qr = w.range_right;
    if (ql < 1 || qr > POSITIONS || ql > qr) begin
      r.range_error = 1'b1;
      return 1'b1;
    end
    // grow first, then shrink, so no count goes negative
    while (win_hi < qr) begin
      win_hi++;
      add_hit(value_at(win_hi));
    end
    while (win_lo > ql) begin
      win_lo--;
      add_hit(value_at(win_lo));
    end
    while (win_lo < ql) begin
      drop_hit(value_at(win_lo));
      win_lo++;
    end
    while (win_hi > qr) begin
      drop_hit(value_at(win_hi));
      win_hi--;
    end
    r.distinct_count = CNT_W'(distinct_now);
    return 1'b1;
  endfunction

  function automatic int clamp_pos(int p);
    if (p < 1) return 1;
    if (p > POSITIONS) return POSITIONS;
    return p;
  endfunction

  // Mostly small window moves and writes near the window, so that counts
  // see repeats and removals; some wide jumps, stray writes and bad ranges.
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    int unsigned sub;
    int          lo;
    int          hi;
    int          t;
    w.cmd         = CMD_WRITE;
    w.position    = POS_W'($urandom());
    w.value       = VAL_W'($urandom());
    w.range_left  = POS_W'($urandom());
    w.range_right = POS_W'($urandom());
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    if (pick < 40) begin
      if (sub < 70) begin
        lo = clamp_pos(int'(win_lo) - 2);
        hi = clamp_pos(((win_hi > win_lo) ? int'(win_hi) : int'(win_lo)) + 2);
        w.position = POS_W'($urandom_range(hi, lo));
      end else if (sub < 90) begin
        w.position = POS_W'($urandom_range(128, 1));
      end else if (sub < 95) begin
        w.position = POS_W'($urandom_range(POSITIONS, 1));
      end
      if ($urandom_range(99) < 70) w.value = VAL_W'($urandom_range(15));
    end else if (pick < 90) begin
      w.cmd = CMD_QUERY;
      if (sub < 74) begin
        lo = clamp_pos(int'(win_lo) + int'($urandom_range(12)) - 6);
        hi = clamp_pos(int'(win_hi) + int'($urandom_range(12)) - 6);
      end else if (sub < 99) begin
        lo = $urandom_range(128, 1);
        hi = $urandom_range(128, 1);
      end else begin
        lo = $urandom_range(POSITIONS, 1);
        hi = $urandom_range(POSITIONS, lo);
      end
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      w.range_left  = POS_W'(lo);
      w.range_right = POS_W'(hi);
    end else begin
      w.cmd = CMD_QUERY;
      case ($urandom_range(2))
        0: begin
          w.range_left  = '0;
          w.range_right = POS_W'($urandom_range(8191));
        end
        1: begin
          w.range_left  = POS_W'($urandom_range(8191, 1));
          w.range_right = POS_W'($urandom_range(8191, POSITIONS + 1));
        end
        default: begin
          w.range_right = POS_W'($urandom_range(POSITIONS - 1, 1));
          w.range_left  = POS_W'($urandom_range(POSITIONS, int'(w.range_right) + 1));
        end
      endcase
    end
    return w;
  endfunction

  // Sends one word; the previous word was taken at the last rising edge.
  task automatic send_word(input in_word_t w);
    out_word_t r;
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do begin
        @(negedge clk);
      end while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(posedge clk);
    end while (in_stall);
    if (apply_word(w, r)) begin
      expected_counts.push_back(r);
      n_queries++;
      if (r.range_error) n_bad_ranges++;
    end else begin
      n_writes++;
    end
  endtask

  task automatic write_word(input int unsigned p, input int unsigned v);
    in_word_t w;
    w          = '0;
    w.cmd      = CMD_WRITE;
    w.position = POS_W'(p);
    w.value    = VAL_W'(v);
    send_word(w);
  endtask

  task automatic query_word(input int unsigned l, input int unsigned r);
    in_word_t w;
    w             = '0;
    w.cmd         = CMD_QUERY;
    w.range_left  = POS_W'(l);
    w.range_right = POS_W'(r);
    send_word(w);
  endtask

  task automatic release_bus();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_bus();
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    query_word(1, 1);
    query_word(0, 5);
    query_word(1, POSITIONS + 1);
    query_word(9, 8);
    query_word(8191, 8191);
    write_word(0, 7);                  // stray positions: ignored
    write_word(8191, 7);
    write_word(POSITIONS + 1, 7);
    write_word(1, 16'hFFFF);           // inside the one-wide window
    write_word(POSITIONS, 16'hFFFF);
    write_word(2, 16'h5555);
    write_word(3, 16'hAAAA);
    query_word(1, POSITIONS);
    write_word(2, 16'hFFFF);           // duplicate value inside window
    write_word(2, 16'hFFFF);           // same value again
    query_word(POSITIONS, POSITIONS);
    query_word(2, 5);
    query_word(4, 9);                  // both bounds move up
    query_word(1, 3);
    write_word(3, 0);
    query_word(1, 3);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned gap,
                                     input int unsigned stall);
    send_gap_pct = gap;
    stall_pct    = stall;
    repeat (count) send_word(random_word());
    wait_drained();
  endtask

  // Receiver holds off while queries keep coming, so the input backs up.
  task automatic test_output_hold();
    in_word_t w;
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_request = HOLD_CYCLES;
    repeat (40) begin
      w = random_word();
      w.cmd = CMD_QUERY;
      send_word(w);
    end
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_gap_pct = 22;
    stall_pct    = 22;
    repeat (3) begin
      repeat (10) send_word(random_word());
      wait_drained();
    end
  endtask

  task automatic finish_run();
    release_bus();
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d writes and %0d queries (%0d with a bad range),",
             n_writes, n_queries, n_bad_ranges);
    $display("%0d results compared over idle, stall and hold-off phases, %0d errors",
             n_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result word: count %0d error %0b",
                 $time, out_word.distinct_count, out_word.range_error);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        n_checked++;
        if (out_word.distinct_count !== want.distinct_count) begin
          $display("%0t: distinct_count expected %0d actual %0d",
                   $time, want.distinct_count, out_word.distinct_count);
          errors++;
        end
        if (out_word.range_error !== want.range_error) begin
          $display("%0t: range_error expected %0b actual %0b",
                   $time, want.range_error, out_word.range_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 45, 0);
    test_random_traffic(400, 0, 45);
    test_random_traffic(400, 22, 22);
    test_output_hold();
    test_drain_pause();
    finish_run();
  end

endmodule

`default_nettype wire

// ===== window_distinct_count_with_updates.f =====
rtl/core/wdc_pkg.sv
rtl/core/wdc_ram.sv
rtl/core/wdc_seq.sv
rtl/core/window_distinct_count_with_updates.sv
tb/tb_top.sv
